### design/bcpe_pkg.sv
// ----------------------------------------------------------------------------
// bcpe_pkg: shared types and constants for the Bezier curve point evaluator
// Holds the word types of both channels, action and status codes, the
// controller states and the command struct between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bcpe_pkg;

  // Fixed field widths of the channel words.
  localparam int unsigned ActionW = 2;
  localparam int unsigned FieldW  = 16;
  localparam int unsigned TParamW = 17;
  localparam int unsigned StatusW = 2;

  typedef enum logic [ActionW-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_EVAL   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FEW   = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [FieldW-1:0]  point_x;
    logic [FieldW-1:0]  point_y;
    logic [TParamW-1:0] param_t;
  } in_word_t;

  typedef struct packed {
    logic [FieldW-1:0]  curve_x;
    logic [FieldW-1:0]  curve_y;
    logic [StatusW-1:0] status;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_ACC,
    S_DONE
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_t;     // latch the saturated parameter
    logic load_pt;    // copy the addressed point into the work array
    logic mul;        // start a product of the current lerp
    logic acc;        // finish the lerp and write it back
    logic finish;     // round the result into the output register
  } dp_cmd_t;

endpackage : bcpe_pkg

`default_nettype wire

### design/bezier_curve_point_eval.sv
// ----------------------------------------------------------------------------
// bezier_curve_point_eval: Bezier curve point evaluator, de Casteljau
// Stores up to MaxPoints control points and evaluates the curve at t.
// ----------------------------------------------------------------------------
// Each accepted word clears the point list, appends a point, evaluates the
// curve at param_t (16 fraction bits, saturated to 1.0), or for ACT_NONE does
// nothing; each returns one result word. Clear, append, none and failed
// evaluates raise the result word in the cycle after they are accepted. An
// evaluate of n points loads them into the work array and then runs n(n-1)/2
// lerps per coordinate on one shared multiplier. One word is worked on at a
// time; the next is taken once the result word has been delivered.
`default_nettype none

module bezier_curve_point_eval import bcpe_pkg::*; #(
  parameter int unsigned MaxPoints = 16,
  parameter int unsigned CoordBits = 16,
  parameter int unsigned TFracBits = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_word_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_data_o
);

  localparam int unsigned IdxW = $clog2(MaxPoints);
  localparam int unsigned CntW = $clog2(MaxPoints + 1);

  dp_cmd_t            cmd;
  logic [IdxW-1:0]    idx;
  logic               coord, half, wr_pt, zero;
  logic [CntW-1:0]    wr_addr;
  logic [StatusW-1:0] status;
  logic [FieldW-1:0]  res_x, res_y;

  bcpe_ctrl #(.MaxPoints(MaxPoints), .IdxW(IdxW), .CntW(CntW)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .action_i(in_data_i.action), .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .idx_o(idx), .coord_o(coord), .half_o(half),
    .wr_pt_o(wr_pt), .wr_addr_o(wr_addr), .status_o(status), .zero_o(zero)
  );

  bcpe_datapath #(
    .MaxPoints(MaxPoints), .CoordBits(CoordBits), .TFracBits(TFracBits),
    .IdxW(IdxW), .CntW(CntW)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .idx_i(idx), .coord_i(coord), .half_i(half),
    .wr_pt_i(wr_pt), .wr_addr_i(wr_addr),
    .wr_x_i(in_data_i.point_x), .wr_y_i(in_data_i.point_y),
    .t_i(in_data_i.param_t), .res_x_o(res_x), .res_y_o(res_y)
  );

  // Coordinates read as zero unless the word is an ok evaluate.
  always_comb begin
    out_data_o.curve_x = zero ? '0 : res_x;
    out_data_o.curve_y = zero ? '0 : res_y;
    out_data_o.status  = status;
  end

endmodule : bezier_curve_point_eval

`default_nettype wire

### design/bcpe_datapath.sv
// ----------------------------------------------------------------------------
// bcpe_datapath: point memory, work array and the shared lerp multiplier
// One lerp of one coordinate forms two products and then accumulates them;
// x and y share a single multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpe_datapath import bcpe_pkg::*; #(
  parameter int unsigned MaxPoints = 16,
  parameter int unsigned CoordBits = 16,
  parameter int unsigned TFracBits = 16,
  parameter int unsigned IdxW      = 4,
  parameter int unsigned CntW      = 5
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dp_cmd_t              cmd_i,
  input  wire logic [IdxW-1:0]      idx_i,     // element index of the lerp
  input  wire logic                 coord_i,   // 0 x, 1 y
  input  wire logic                 half_i,    // 0 first product, 1 second
  input  wire logic                 wr_pt_i,   // append write
  input  wire logic [CntW-1:0]      wr_addr_i,
  input  wire logic [FieldW-1:0]    wr_x_i,
  input  wire logic [FieldW-1:0]    wr_y_i,
  input  wire logic [TParamW-1:0]   t_i,
  output logic [FieldW-1:0]         res_x_o,
  output logic [FieldW-1:0]         res_y_o
);

  localparam int unsigned WorkW = CoordBits + 16;
  localparam int unsigned TW    = TFracBits + 1;
  localparam int unsigned ProdW = WorkW + TW;
  localparam int unsigned CmpW  = (TW > TParamW) ? TW : TParamW;
  localparam logic [TW-1:0] TOne = TW'(1) << TFracBits;

  logic [2*CoordBits-1:0] pts_mem [MaxPoints];
  logic [2*CoordBits-1:0] rd_q;
  logic [WorkW-1:0]       wx_q [MaxPoints];
  logic [WorkW-1:0]       wy_q [MaxPoints];
  logic [TW-1:0]          t_q;
  logic [ProdW-1:0]       prod_q;
  logic [ProdW-1:0]       sum_q;
  logic [WorkW-1:0]       op_a, op_b, op;
  logic [TW-1:0]          mul_t;
  logic [ProdW-1:0]       total;
  logic [WorkW-1:0]       lerp_val;
  logic [WorkW-1:0]       rnd_x, rnd_y;
  logic [TW-1:0]          t_sat;

  // Point memory: one write port, registered read.
  always_ff @(posedge clk_i) begin
    if (wr_pt_i) begin
      pts_mem[wr_addr_i[IdxW-1:0]] <= {CoordBits'(wr_x_i), CoordBits'(wr_y_i)};
    end
    rd_q <= pts_mem[idx_i];
  end

  // Saturate the parameter to one.
  always_comb begin
    t_sat = (CmpW'(t_i) > CmpW'(TOne)) ? TOne : TW'(t_i);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a  = coord_i ? wy_q[idx_i] : wx_q[idx_i];
    op_b  = coord_i ? wy_q[idx_i + IdxW'(1)] : wx_q[idx_i + IdxW'(1)];
    op    = half_i ? op_b : op_a;
    mul_t = half_i ? t_q : (TOne - t_q);
    total = sum_q + prod_q + ProdW'(TOne >> 1);
    lerp_val = WorkW'(total >> TFracBits);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_t) begin
      t_q <= t_sat;
    end
    if (cmd_i.mul) begin
      prod_q <= ProdW'(op) * ProdW'(mul_t);
      sum_q  <= half_i ? prod_q : '0;
    end
    if (cmd_i.load_pt) begin
      wx_q[idx_i] <= {rd_q[2*CoordBits-1:CoordBits], 16'd0};
      wy_q[idx_i] <= {rd_q[CoordBits-1:0], 16'd0};
    end
    if (cmd_i.acc) begin
      if (coord_i) begin
        wy_q[idx_i] <= lerp_val;
      end else begin
        wx_q[idx_i] <= lerp_val;
      end
    end
  end

  // Final rounding to integer coordinates.
  always_comb begin
    rnd_x = WorkW'((wx_q[0] + WorkW'(1 << 15)) >> 16);
    rnd_y = WorkW'((wy_q[0] + WorkW'(1 << 15)) >> 16);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_x_o <= FieldW'(rnd_x[CoordBits-1:0]);
      res_y_o <= FieldW'(rnd_y[CoordBits-1:0]);
    end
  end

  // The reset is not needed by the payload registers above.
  logic unused_rst;
  assign unused_rst = rst_ni;

endmodule : bcpe_datapath

`default_nettype wire

### design/bcpe_ctrl.sv
// ----------------------------------------------------------------------------
// bcpe_ctrl: controller of the Bezier curve point evaluator
// Owns the handshakes and the point count, and sequences loading and the
// triangle of lerps for an evaluate.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpe_ctrl import bcpe_pkg::*; #(
  parameter int unsigned MaxPoints = 16,
  parameter int unsigned IdxW      = 4,
  parameter int unsigned CntW      = 5
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [ActionW-1:0] action_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output dp_cmd_t                 cmd_o,
  output logic [IdxW-1:0]         idx_o,
  output logic                    coord_o,
  output logic                    half_o,
  output logic                    wr_pt_o,
  output logic [CntW-1:0]         wr_addr_o,
  output logic [StatusW-1:0]      status_o,
  output logic                    zero_o
);

  ctrl_state_e state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [IdxW-1:0]    lvl_q, lvl_d;   // lerps in current level
  logic               coord_q, coord_d;
  logic               half_q, half_d;
  logic               ovalid_q, ovalid_d;
  logic [StatusW-1:0] status_q, status_d;
  logic               zero_q, zero_d;
  logic               accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      lvl_q    <= '0;
      coord_q  <= 1'b0;
      half_q   <= 1'b0;
      ovalid_q <= 1'b0;
      status_q <= ST_OK;
      zero_q   <= 1'b1;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      lvl_q    <= lvl_d;
      coord_q  <= coord_d;
      half_q   <= half_d;
      ovalid_q <= ovalid_d;
      status_q <= status_d;
      zero_q   <= zero_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    lvl_d    = lvl_q;
    coord_d  = coord_q;
    half_d   = half_q;
    status_d = status_q;
    zero_d   = zero_q;
    cmd_o    = '0;
    wr_pt_o  = 1'b0;
    ovalid_d = ovalid_q && !out_ready_i;
    in_ready_o = (state_q == S_IDLE) && !ovalid_q;
    accept   = in_valid_i && in_ready_o;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          zero_d   = 1'b1;
          status_d = ST_OK;
          ovalid_d = 1'b1;
          case (action_e'(action_i))
            ACT_CLEAR: count_d = '0;
            ACT_APPEND: begin
              if (count_q >= CntW'(MaxPoints)) begin
                status_d = ST_FULL;
              end else begin
                wr_pt_o = 1'b1;
                count_d = count_q + CntW'(1);
              end
            end
            ACT_EVAL: begin
              if (count_q < CntW'(2)) begin
                status_d = ST_FEW;
              end else begin
                ovalid_d   = 1'b0;
                zero_d     = 1'b0;
                cmd_o.take_t = 1'b1;
                idx_d      = '0;
                state_d    = S_LOAD;
              end
            end
            default: ;
          endcase
        end
      end
      // Memory read of idx_q is registered; write it into the work array in the next cycle.
      S_LOAD: begin
        if (half_q) begin
          cmd_o.load_pt = 1'b1;
          half_d = 1'b0;
          if (CntW'(idx_q) == count_q - CntW'(1)) begin
            idx_d   = '0;
            lvl_d   = IdxW'(count_q - CntW'(1));
            coord_d = 1'b0;
            state_d = S_MUL;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end else begin
          half_d = 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        if (half_q) begin
          half_d  = 1'b0;
          state_d = S_ACC;
        end else begin
          half_d = 1'b1;
        end
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = S_MUL;
        if (!coord_q) begin
          coord_d = 1'b1;
        end else begin
          coord_d = 1'b0;
          if (idx_q == lvl_q - IdxW'(1)) begin
            idx_d = '0;
            lvl_d = lvl_q - IdxW'(1);
            if (lvl_q == IdxW'(1)) begin
              state_d = S_DONE;
            end
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        ovalid_d     = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign idx_o       = idx_q;
  assign coord_o     = coord_q;
  assign half_o      = half_q;
  assign wr_addr_o   = count_q;
  assign out_valid_o = ovalid_q;
  assign status_o    = status_q;
  assign zero_o      = zero_q;

endmodule : bcpe_ctrl

`default_nettype wire

### verif/bezier_curve_point_eval_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_curve_point_eval_tb: self-checking bench for the Bezier evaluator
// Sends clear, append, evaluate and no-op words with random gaps on both channels.
// An internal de Casteljau model predicts each result word, and the monitor
// checks every result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module bezier_curve_point_eval_tb;
  import bcpe_pkg::*;

  localparam int unsigned NumPts   = 16;
  localparam int unsigned CycLimit = 3_000_000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_data_o;

  bezier_curve_point_eval i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Words waiting to be sent, and result words still to arrive.
  in_word_t  send_q[$];
  out_word_t curve_expect_q[$];

  // Model copy of the point list.
  logic [15:0] mdl_x[NumPts];
  logic [15:0] mdl_y[NumPts];
  int unsigned mdl_count;

  int unsigned err_count;
  int unsigned cyc_count;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned evals_sent;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          hold_send;

  // Short gaps mostly, with an occasional long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // De Casteljau evaluation in the block's fixed point, with state update.
  function automatic out_word_t predict_curve(in_word_t w);
    out_word_t   res;
    logic [63:0] wx[NumPts];
    logic [63:0] wy[NumPts];
    logic [63:0] t;
    logic [63:0] one;
    int unsigned lvl;
    res = '0;
    res.status = ST_OK;
    one = 64'd1 << 16;
    case (action_e'(w.action))
      ACT_CLEAR: mdl_count = 0;
      ACT_APPEND: begin
        if (mdl_count >= NumPts) begin
          res.status = ST_FULL;
        end else begin
          mdl_x[mdl_count] = w.point_x;
          mdl_y[mdl_count] = w.point_y;
          mdl_count++;
        end
      end
      ACT_EVAL: begin
        if (mdl_count < 2) begin
          res.status = ST_FEW;
        end else begin
          t = (w.param_t > one) ? one : 64'(w.param_t);
          for (int i = 0; i < mdl_count; i++) begin
            wx[i] = 64'(mdl_x[i]) << 16;
            wy[i] = 64'(mdl_y[i]) << 16;
          end
          for (lvl = mdl_count - 1; lvl > 0; lvl--) begin
            for (int i = 0; i < lvl; i++) begin
              wx[i] = ((one - t) * wx[i] + t * wx[i+1] + (one >> 1)) >> 16;
              wy[i] = ((one - t) * wy[i] + t * wy[i+1] + (one >> 1)) >> 16;
            end
          end
          res.curve_x = 16'((wx[0] + 64'h8000) >> 16);
          res.curve_y = 16'((wy[0] + 64'h8000) >> 16);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH word %0d: %s got %0d, expected %0d", words_checked, what, got,
             want);
    err_count++;
  endtask

  function automatic in_word_t make_word(action_e a, int unsigned x, int unsigned y,
                                         int unsigned t);
    in_word_t w;
    w.action  = a;
    w.point_x = 16'(x);
    w.point_y = 16'(y);
    w.param_t = 17'(t);
    return w;
  endfunction

  // Append one word to the end of the send queue.
  task automatic add_word(in_word_t w);
    send_q = {send_q, w};
  endtask

  function automatic int unsigned rand_t();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return 65536;
    if (r == 2) return $urandom_range(65537, 131071);
    return $urandom_range(0, 65536);
  endfunction

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Stimulus: directed words first, then random point sets.
  initial begin
    int unsigned n;
    rst_ni    = 1'b0;
    // Too few points, then edge coordinates and parameter extremes.
    add_word(make_word(ACT_EVAL, 0, 0, 32768));
    add_word(make_word(ACT_APPEND, 65535, 0, 0));
    add_word(make_word(ACT_EVAL, 0, 0, 32768));
    add_word(make_word(ACT_APPEND, 0, 65535, 131071));
    add_word(make_word(ACT_EVAL, 0, 0, 0));
    add_word(make_word(ACT_EVAL, 0, 0, 65536));
    add_word(make_word(ACT_EVAL, 0, 0, 131071));
    add_word(make_word(ACT_EVAL, 0, 0, 32768));
    add_word(make_word(ACT_NONE, 65535, 65535, 131071));
    add_word(make_word(ACT_EVAL, 65535, 65535, 1));
    add_word(make_word(ACT_CLEAR, 0, 0, 0));
    add_word(make_word(ACT_EVAL, 0, 0, 1));
    // Fill the list, overflow it, and evaluate with all sixteen points.
    for (int i = 0; i < NumPts + 1; i++) begin
      add_word(make_word(ACT_APPEND, (i % 2) ? 65535 : 0, (i % 3) ? 0 : 65535, 0));
    end
    add_word(make_word(ACT_EVAL, 0, 0, 21845));
    add_word(make_word(ACT_CLEAR, 0, 0, 0));
    // Random point sets, mostly small, with some noise between them.
    while (send_q.size() < 950) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 18) : $urandom_range(0, 6);
      add_word(make_word(ACT_CLEAR, $urandom(), $urandom(), $urandom()));
      for (int i = 0; i < n; i++) begin
        add_word(make_word(ACT_APPEND, $urandom(), $urandom(), $urandom()));
      end
      repeat ($urandom_range(1, 4)) begin
        add_word(make_word(ACT_EVAL, $urandom(), $urandom(), rand_t()));
      end
      if ($urandom_range(0, 7) == 0) begin
        add_word(make_word(action_e'($urandom_range(0, 3)), $urandom(),
                           $urandom(), $urandom()));
      end
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: one word at a time from the send queue.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      gap_left   <= 0;
      words_sent <= 0;
      evals_sent <= 0;
      hold_send  = 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        curve_expect_q = {curve_expect_q, predict_curve(in_data_i)};
        words_sent <= words_sent + 1;
        if (in_data_i.action == ACT_EVAL) evals_sent <= evals_sent + 1;
        // After 401 words have been sent, hold off until the block has drained.
        if (words_sent == 400) hold_send = 1'b1;
        gap_left <= pick_gap();
        in_valid_i <= 1'b0;
      end else if (!in_valid_i) begin
        if (hold_send && curve_expect_q.size() == 0) hold_send = 1'b0;
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (!hold_send && send_q.size() != 0) begin
          in_data_i  <= send_q.pop_front();
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // Monitor: random back-pressure and field checks.
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      out_ready_i   <= 1'b0;
      stall_left    <= 0;
      words_checked <= 0;
      err_count     = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (curve_expect_q.size() == 0) begin
          $display("MISMATCH: unexpected result word");
          err_count++;
        end else begin
          want = curve_expect_q.pop_front();
          if (out_data_o.curve_x !== want.curve_x)
            report_mismatch("curve_x", 32'(out_data_o.curve_x), 32'(want.curve_x));
          if (out_data_o.curve_y !== want.curve_y)
            report_mismatch("curve_y", 32'(out_data_o.curve_y), 32'(want.curve_y));
          if (out_data_o.status !== want.status)
            report_mismatch("status", 32'(out_data_o.status), 32'(want.status));
        end
        words_checked <= words_checked + 1;
      end
      if (stall_left != 0) begin
        stall_left  <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        stall_left  <= pick_gap();
      end
    end
  end

  // End of run and timeout.
  initial begin
    cyc_count = 0;
    @(posedge rst_ni);
    while ((send_q.size() != 0 || in_valid_i || curve_expect_q.size() != 0)
           && cyc_count < CycLimit) begin
      @(posedge clk_i);
      cyc_count++;
    end
    if (cyc_count >= CycLimit) begin
      $display("Timeout after %0d cycles", cyc_count);
      $display("TEST FAILED");
    end else begin
      repeat (800) @(posedge clk_i);
      $display("Sent %0d words (%0d evaluates), checked %0d results, %0d mismatches.",
               words_sent, evals_sent, words_checked, err_count);
      if (err_count == 0 && curve_expect_q.size() == 0) begin
        $display("TEST PASSED");
      end else begin
        $display("TEST FAILED");
      end
    end
    $finish;
  end

endmodule

### bezier_curve_point_eval.f
design/bcpe_pkg.sv
design/bcpe_datapath.sv
design/bcpe_ctrl.sv
design/bezier_curve_point_eval.sv
verif/bezier_curve_point_eval_tb.sv
